// ===== rtl/rde_pkg.sv =====
// ----------------------------------------------------------------------------
// rde_pkg
// Shared constants, types and the digit-to-ASCII mapping of the radix digit
// emitter.
// ----------------------------------------------------------------------------
package rde_pkg;

  // Field widths
  localparam int VALUE_BITS = 31;
  localparam int RADIX_W    = 6;
  localparam int CHAR_W     = 7;
  localparam int CNT_W      = $clog2(VALUE_BITS);

  // Radix limits
  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(35);
  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_MIN;

  // ASCII mapping
  localparam logic [RADIX_W-1:0] DECIMAL_LIMIT    = RADIX_W'(10);
  localparam logic [CHAR_W-1:0]  ASCII_ZERO       = CHAR_W'(48);
  localparam logic [CHAR_W-1:0]  ASCII_ALPHA_BIAS = CHAR_W'(55);
  localparam logic [CHAR_W-1:0]  ASCII_TOP        = CHAR_W'(89);

  // Last bit position of a division pass
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_BITS - 1);

  // Commands to the serial divider
  typedef struct packed {
    logic load;   // take a new dividend and start a pass
    logic again;  // divide the held quotient once more
  } div_ctrl_t;

  // Status from the serial divider
  typedef struct packed {
    logic               done;       // pass finished this cycle
    logic [RADIX_W-1:0] digit;      // remainder of the pass
    logic               quot_zero;  // quotient of the pass is zero
  } div_stat_t;

  // Map a digit value to its ASCII character
  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] ext;
    ext = {{(CHAR_W-RADIX_W){1'b0}}, d};
    if (d < DECIMAL_LIMIT) begin
      return ext + ASCII_ZERO;
    end
    return ext + ASCII_ALPHA_BIAS;
  endfunction

endpackage

// ===== rtl/rde_serial_div.sv =====
// ----------------------------------------------------------------------------
// rde_serial_div
// Bit-serial restoring divider: shifts the dividend out one bit per cycle
// into a narrow remainder and shifts quotient bits back in behind it.
// ----------------------------------------------------------------------------
module rde_serial_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rde_pkg::div_ctrl_t            ctrl_i,
  input  logic [rde_pkg::VALUE_BITS-1:0] value_i,
  input  logic [rde_pkg::RADIX_W-1:0]    radix_i,
  output rde_pkg::div_stat_t            stat_o
);
  import rde_pkg::*;

  logic [VALUE_BITS-1:0] quot_q, quot_d;
  logic [RADIX_W-1:0]    rem_q, rem_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  nz_q, nz_d;
  logic                  run_q, run_d;
  logic                  done_q, done_d;

  logic [RADIX_W:0] trial;
  logic [RADIX_W:0] diff;
  logic             ge;

  // Trial subtract of the radix from the shifted remainder
  assign trial = {rem_q, quot_q[VALUE_BITS-1]};
  assign diff  = trial - {1'b0, radix_i};
  assign ge    = (trial >= {1'b0, radix_i});

  // Next state of the shift register and pass counter
  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    nz_d   = nz_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (ctrl_i.load || ctrl_i.again) begin
      if (ctrl_i.load) begin
        quot_d = value_i;
      end
      rem_d = '0;
      cnt_d = '0;
      nz_d  = 1'b0;
      run_d = 1'b1;
    end else if (run_q) begin
      quot_d = {quot_q[VALUE_BITS-2:0], ge};
      rem_d  = ge ? diff[RADIX_W-1:0] : trial[RADIX_W-1:0];
      nz_d   = nz_q | ge;
      cnt_d  = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_LAST) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    nz_q   <= nz_d;
  end

  assign stat_o.done      = done_q;
  assign stat_o.digit     = rem_q;
  assign stat_o.quot_zero = ~nz_q;

endmodule

// ===== rtl/radix_digit_emitter.sv =====
// ----------------------------------------------------------------------------
// radix_digit_emitter
// Converts a non-negative integer into ASCII digits of a configured radix,
// least significant digit first, marking the final digit of each run.
// ----------------------------------------------------------------------------
//   channel   | direction | handshake                  | payload
//   ----------+-----------+----------------------------+--------------------------
//   command   | in        | start_i high, busy_o low   | value_i
//   result    | out       | digit_strobe_o, one cycle  | digit_char_o, last_digit_o
//   radix     | in        | radix_we_i                 | radix_i
//
// A zero value gives its single '0' beat in the cycle after the command.
// Any other value is divided down pass by pass: each bit-serial divider
// pass shifts in the VALUE_BITS quotient bits, then presents the
// remainder as the digit and reloads the quotient for the next pass
// while it is non-zero. busy_o stays high for the whole run; the last
// beat shows as busy_o falls. Reset leaves the block idle with radix 2.
// The receiver cannot stall: each beat shows for one cycle.
// ----------------------------------------------------------------------------
module radix_digit_emitter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [rde_pkg::VALUE_BITS-1:0]  value_i,
  input  logic                            radix_we_i,
  input  logic [rde_pkg::RADIX_W-1:0]     radix_i,
  output logic                            digit_strobe_o,
  output logic [rde_pkg::CHAR_W-1:0]      digit_char_o,
  output logic                            last_digit_o
);
  import rde_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e             state_q;
  logic [RADIX_W-1:0] radix_q, radix_d;
  logic               strobe_q;
  logic [CHAR_W-1:0]  char_q;
  logic               last_q;

  div_ctrl_t div_ctrl;
  div_stat_t div_stat;
  logic      accept;

  assign accept = start_i && (state_q == ST_IDLE);

  // Clamp radix writes into the supported range
  always_comb begin
    radix_d = radix_i;
    if (radix_i > RADIX_MAX) begin
      radix_d = RADIX_MAX;
    end else if (radix_i < RADIX_MIN) begin
      radix_d = RADIX_MIN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RADIX_RESET;
    end else if (radix_we_i) begin
      radix_q <= radix_d;
    end
  end

  // Divider commands: load on a non-zero command, repeat while quotient remains
  assign div_ctrl.load  = accept && (value_i != '0);
  assign div_ctrl.again = (state_q == ST_RUN) && div_stat.done && !div_stat.quot_zero;

  rde_serial_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (div_ctrl),
    .value_i(value_i),
    .radix_i(radix_q),
    .stat_o (div_stat)
  );

  // Sequence the run and register each result beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      strobe_q <= 1'b0;
      char_q   <= ASCII_ZERO;
      last_q   <= 1'b0;
    end else begin
      strobe_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (value_i == '0) begin
              strobe_q <= 1'b1;
              char_q   <= ASCII_ZERO;
              last_q   <= 1'b1;
            end else begin
              state_q <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          if (div_stat.done) begin
            strobe_q <= 1'b1;
            char_q   <= digit_to_ascii(div_stat.digit);
            last_q   <= div_stat.quot_zero;
            if (div_stat.quot_zero) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign digit_strobe_o = strobe_q;
  assign digit_char_o   = char_q;
  assign last_digit_o   = last_q;

`ifndef SYNTHESIS
  // Stored radix always stays within the clamp limits
  a_radix_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (radix_q >= RADIX_MIN) && (radix_q <= RADIX_MAX))
    else $error("radix register out of range");

  // A zero command yields one final '0' beat next cycle
  a_zero_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (value_i == '0)) |=>
      (digit_strobe_o && last_digit_o && (digit_char_o == ASCII_ZERO)))
    else $error("zero value did not give a single final digit");

  // A non-zero command starts a run
  a_run_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (value_i != '0)) |=> busy_o)
    else $error("run did not start");

  // Inside a run, digit beats never come back to back
  a_beat_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (digit_strobe_o && !last_digit_o) |=> !digit_strobe_o)
    else $error("digit beats too close");

  // Every beat carries a valid digit character
  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    digit_strobe_o |-> ((digit_char_o >= ASCII_ZERO) && (digit_char_o <= ASCII_TOP)))
    else $error("digit character out of range");
`endif

endmodule

// ===== dv/tb_radix_digit_emitter.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_radix_digit_emitter
// Self-checking bench for the radix digit emitter. Values are driven through
// the start/busy command port under several radix settings, each expected
// digit run is worked out at acceptance and every digit beat is compared in
// order against it. Directed corner values come first, then random phases
// with varying sender idling.
// ----------------------------------------------------------------------------
module tb_radix_digit_emitter;
  import rde_pkg::*;

  // Longest quiet stretch: one digit pass plus sender gaps and the
  // settling pause around a radix write, taken with a wide margin
  localparam int QUIET_LIMIT = 4000;
  localparam int PHASES      = 12;
  localparam int PER_PHASE   = 26;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } digit_beat_t;

  // Expected digit beats, oldest first
  class digit_scoreboard;
    digit_beat_t expected_q[$];
    int unsigned mismatches;
    int unsigned beats_checked;
    int unsigned values_taken;

    function new();
      mismatches    = 0;
      beats_checked = 0;
      values_taken  = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Divide down the accepted value and queue its digits, lowest first
    function void note_value(logic [VALUE_BITS-1:0] value, logic [RADIX_W-1:0] base);
      logic [VALUE_BITS-1:0] quo;
      logic [VALUE_BITS-1:0] rem;
      digit_beat_t           beat;
      values_taken++;
      quo = value;
      if (quo == '0) begin
        beat.ch   = ASCII_ZERO;
        beat.last = 1'b1;
        expected_q.insert(expected_q.size(), beat);
        return;
      end
      while (quo != '0) begin
        rem = quo % base;
        quo = quo / base;
        if (rem < DECIMAL_LIMIT) begin
          beat.ch = rem[CHAR_W-1:0] + ASCII_ZERO;
        end else begin
          beat.ch = rem[CHAR_W-1:0] + ASCII_ALPHA_BIAS;
        end
        beat.last = (quo == '0);
        expected_q.insert(expected_q.size(), beat);
      end
    endfunction

    // Compare one digit beat with the oldest expectation
    function void check_digit(logic [CHAR_W-1:0] ch, logic last);
      digit_beat_t want;
      beats_checked++;
      if (expected_q.size() == 0) begin
        $error("unexpected digit beat: digit_char %0d last_digit %0d", ch, last);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      if (ch !== want.ch) begin
        $error("digit_char: expected %0d, got %0d", want.ch, ch);
        mismatches++;
      end
      if (last !== want.last) begin
        $error("last_digit: expected %0d, got %0d", want.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start_i;
  logic                  busy_o;
  logic [VALUE_BITS-1:0] value_i;
  logic                  radix_we_i;
  logic [RADIX_W-1:0]    radix_i;
  logic                  digit_strobe_o;
  logic [CHAR_W-1:0]     digit_char_o;
  logic                  last_digit_o;

  digit_scoreboard       sb;
  logic [RADIX_W-1:0]    radix_now;
  int unsigned           idle_pct;
  int unsigned           radix_settings;
  int unsigned           quiet_cycles;

  radix_digit_emitter uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .value_i        (value_i),
    .radix_we_i     (radix_we_i),
    .radix_i        (radix_i),
    .digit_strobe_o (digit_strobe_o),
    .digit_char_o   (digit_char_o),
    .last_digit_o   (last_digit_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Check every digit beat at the edge that ends its cycle
  always @(posedge clk_i) begin
    if (rst_ni && digit_strobe_o) begin
      sb.check_digit(digit_char_o, last_digit_o);
    end
  end

  // Watchdog: give up after too long without a command or digit beat
  always @(posedge clk_i) begin
    if (!rst_ni || digit_strobe_o || (start_i && !busy_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("radix_digit_emitter verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Wait until every expected digit has come out, then let the block settle
  task automatic drain();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write the radix while idle; hold the clamped setting for prediction
  task automatic set_radix(input logic [RADIX_W-1:0] raw);
    @(negedge clk_i);
    start_i = 1'b0;
    drain();
    @(negedge clk_i);
    radix_we_i = 1'b1;
    radix_i    = raw;
    @(negedge clk_i);
    radix_we_i = 1'b0;
    if (raw > RADIX_MAX) begin
      radix_now = RADIX_MAX;
    end else if (raw < RADIX_MIN) begin
      radix_now = RADIX_MIN;
    end else begin
      radix_now = raw;
    end
    radix_settings++;
  endtask

  // Offer one value, idling first at the phase's rate, and note it on accept
  task automatic send_value(input logic [VALUE_BITS-1:0] v);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      start_i = 1'b0;
      @(negedge clk_i);
    end
    start_i = 1'b1;
    value_i = v;
    do @(posedge clk_i); while (busy_o);
    sb.note_value(v, radix_now);
  endtask

  initial begin
    logic [VALUE_BITS-1:0] v;
    longint                pw;
    int unsigned           pick;
    int unsigned           k;

    sb             = new();
    radix_now      = RADIX_RESET;
    idle_pct       = 0;
    radix_settings = 0;
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    value_i        = '0;
    radix_we_i     = 1'b0;
    radix_i        = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reset radix, zero, single digit, widest runs
    send_value('0);
    send_value(31'd1);
    send_value(31'h7FFF_FFFF);
    send_value(31'h4000_0000);
    // Radix writes below two fall back to binary
    set_radix(6'd0);
    send_value(31'd5);
    set_radix(6'd1);
    send_value(31'd6);
    // Step from '9' to 'A'
    set_radix(6'd11);
    send_value(31'd9);
    send_value(31'd10);
    set_radix(6'd10);
    send_value(31'd1234567890);
    set_radix(6'd16);
    send_value(31'h5555_5555);
    send_value(31'h2AAA_AAAA);
    // Top radix: zero, 'Y', carry into a second digit, full value
    set_radix(6'd35);
    send_value('0);
    send_value(31'd34);
    send_value(31'd35);
    send_value(31'h7FFF_FFFF);
    // Radix writes above the top clamp to 35
    set_radix(6'd63);
    send_value(31'd34);
    send_value(31'd1225);
    set_radix(6'd36);
    send_value(31'h7FFF_FFFF);

    // Random phases; the receiver cannot stall, so only sender idling varies
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       set_radix(6'd2);
        1:       set_radix(6'd35);
        2:       set_radix(6'd0);
        3:       set_radix(6'd63);
        default: set_radix(RADIX_W'($urandom_range(0, 63)));
      endcase
      case (ph % 3)
        0:       idle_pct = 0;
        1:       idle_pct = 55;
        default: idle_pct = 21;
      endcase
      for (int n = 0; n < PER_PHASE; n++) begin
        pick = $urandom_range(99);
        if (pick < 4) begin
          v = '0;
        end else if (pick < 8) begin
          v = '1;
        end else if (pick < 20) begin
          // Exact powers of the radix and one below them
          pw = 1;
          k  = $urandom_range(1, 30);
          while (k > 0 && pw * radix_now < 64'h8000_0000) begin
            pw = pw * radix_now;
            k--;
          end
          v = (pick < 14) ? VALUE_BITS'(pw) : VALUE_BITS'(pw - 1);
        end else begin
          // Spread value sizes so short and long runs both occur
          v = VALUE_BITS'($urandom >> $urandom_range(1, 31));
        end
        send_value(v);
      end
    end
    @(negedge clk_i);
    start_i = 1'b0;

    // Drain the last runs and watch for stray beats
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("Converted %0d values under %0d radix settings, %0d digit beats checked",
             sb.values_taken, radix_settings, sb.beats_checked);
    if (sb.mismatches == 0) begin
      $display("radix_digit_emitter verification clean");
    end else begin
      $display("radix_digit_emitter verification failed");
    end
    $finish;
  end

endmodule
